// File: hw/rtl/fpec_pkg.sv
package fpec_pkg;

  // Defaults for the top-level parameters.
  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;

  // Request codes.
  localparam logic [2:0] REQ_PREFETCH  = 3'd0;
  localparam logic [2:0] REQ_LOAD      = 3'd1;
  localparam logic [2:0] REQ_RELEASE   = 3'd2;
  localparam logic [2:0] REQ_LOAD_DONE = 3'd3;
  localparam logic [2:0] REQ_READ_STAT = 3'd4;
  localparam logic [2:0] REQ_CLEAR     = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_ENTRIES    = 2'd0;
  localparam logic [1:0] CFG_BOUNDED_MODE   = 2'd1;
  localparam logic [1:0] CFG_ARCHIVE_SEALED = 2'd2;

  // Tier codes.
  localparam logic [1:0] TIER_LEGACY = 2'd0;
  localparam logic [1:0] TIER_FAST   = 2'd1;
  localparam logic [1:0] TIER_CARRY  = 2'd2;
  localparam logic [1:0] TIER_COLD   = 2'd3;

  // Event counter indexes.
  localparam int CNT_LOADS      = 0;
  localparam int CNT_HITS       = 1;
  localparam int CNT_PREFETCHES = 2;
  localparam int CNT_RETAINED   = 3;
  localparam int CNT_EVICTIONS  = 4;
  localparam int CNT_FAST_LOADS = 5;
  localparam int CNT_REUSE_HIT  = 6;
  localparam int CNT_REUSE_COLD = 7;

  // Width of the counter snapshot compares against the entry limit.
  localparam int CMP_W = 8;

endpackage

// File: hw/rtl/fifo_pinned_entry_cache_policy.sv
// Entry table with FIFO eviction and pinning, driven by one request at a time.
// A request is taken when start is high and busy is low; busy then stays high
// through the single result beat, which appears on the out_ ports for exactly
// one cycle, marked by out_valid. It must be captured then, since it cannot be
// held off. Every lookup walks the table one entry per cycle through a single
// compare unit. A prefetch or load runs one walk, the stale check, the
// decision, the update, the trim check and the result beat, and a cold
// fallback adds a second walk with another stale check and decision. In
// bounded mode each trim round adds an oldest-entry search over the table and
// a drop step, and a round that evicts returns to the trim check. A release
// runs one walk, the pin release step, the trim check and any trimming, a
// load_done one walk, read_stat a counter read, and clear and unknown
// requests nothing; each ends in the result beat. Configuration writes take
// effect at once and must only be made while the block is idle.
module fifo_pinned_entry_cache_policy
  import fpec_pkg::*;
#(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_key_tag,
  input  logic [1:0]  in_tier,
  input  logic        in_reuse_only,
  input  logic [63:0] in_content_identity,
  input  logic [31:0] in_gen_in,
  input  logic [2:0]  in_stat_index,
  output logic        out_valid,
  output logic        out_hit,
  output logic [1:0]  out_effective_tier,
  output logic [31:0] out_gen_out,
  output logic        out_start_load,
  output logic [4:0]  out_evicted_now,
  output logic [63:0] out_stat_value,
  output logic        out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_LOOK      = 4'd1;
  localparam logic [3:0] S_CHECK     = 4'd2;
  localparam logic [3:0] S_DECIDE    = 4'd3;
  localparam logic [3:0] S_APPLY     = 4'd4;
  localparam logic [3:0] S_REL       = 4'd5;
  localparam logic [3:0] S_TRIM_CHK  = 4'd6;
  localparam logic [3:0] S_TRIM_SCAN = 4'd7;
  localparam logic [3:0] S_TRIM_DROP = 4'd8;
  localparam logic [3:0] S_DONE_SCAN = 4'd9;
  localparam logic [3:0] S_STAT      = 4'd10;
  localparam logic [3:0] S_OUT       = 4'd11;

  // Configuration registers.
  logic [4:0] max_entries_r;
  logic       bounded_r;
  logic       sealed_r;

  // Entry table.
  logic                valid_r   [ENTRIES];
  logic [KEY_BITS-1:0] ekey_r    [ENTRIES];
  logic [1:0]          etier_r   [ENTRIES];
  logic                eback_r   [ENTRIES];
  logic [63:0]         eident_r  [ENTRIES];
  logic [7:0]          epins_r   [ENTRIES];
  logic                eready_r  [ENTRIES];
  logic [31:0]         egen_r    [ENTRIES];
  logic [31:0]         next_gen_r;
  logic [63:0]         cnt_r     [8];
  logic [LW-1:0]       live_r;

  // Request and sequencer registers.
  logic [3:0]          state_r;
  logic [2:0]          req_r;
  logic [KEY_BITS-1:0] key_r;
  logic [1:0]          tier_r;
  logic                reuse_r;
  logic [63:0]         ident_r;
  logic [31:0]         gen_r;
  logic [2:0]          sidx_r;
  logic [IW-1:0]       idx_r;
  logic                mfound_r;
  logic [IW-1:0]       midx_r;
  logic                ffound_r;
  logic [IW-1:0]       fidx_r;
  logic                vfound_r;
  logic [IW-1:0]       vidx_r;
  logic [31:0]         best_age_r;
  logic [4:0]          ev_r;
  logic                hit_r;
  logic [31:0]         gen_out_r;
  logic                start_load_r;
  logic                status_r;
  logic [63:0]         stat_r;

  // Shared compare unit on the entry under the scan index.
  logic          cur_match;
  logic          cur_elig;
  logic [31:0]   cur_age;
  logic          tier_fast;
  logic [CMP_W-1:0] limit;
  logic [7:0]    cnt_inc;

  assign cur_match = valid_r[idx_r] && (ekey_r[idx_r] == key_r) &&
                     (etier_r[idx_r] == tier_r) && (eback_r[idx_r] == sealed_r);
  assign cur_elig  = valid_r[idx_r] && (epins_r[idx_r] == 8'd0) && eready_r[idx_r] &&
                     !cur_match;
  assign cur_age   = next_gen_r - egen_r[idx_r];
  assign tier_fast = (tier_r == TIER_FAST) || (tier_r == TIER_CARRY);
  assign limit     = (max_entries_r == 5'd0) ? CMP_W'(1) : CMP_W'(max_entries_r);

  // Which event counters step this cycle.
  always_comb begin
    cnt_inc = '0;
    case (state_r)
      S_CHECK: begin
        if (mfound_r && ident_r != 64'd0 && eident_r[midx_r] != ident_r) begin
          cnt_inc[CNT_EVICTIONS] = 1'b1;
        end
      end
      S_DECIDE: begin
        if (reuse_r && tier_fast) begin
          if (mfound_r) cnt_inc[CNT_REUSE_HIT] = 1'b1;
          else cnt_inc[CNT_REUSE_COLD] = 1'b1;
        end
      end
      S_APPLY: begin
        if (mfound_r) begin
          cnt_inc[CNT_HITS] = 1'b1;
        end else if (ffound_r) begin
          cnt_inc[CNT_LOADS]      = 1'b1;
          cnt_inc[CNT_PREFETCHES] = (req_r == REQ_PREFETCH);
          cnt_inc[CNT_FAST_LOADS] = tier_fast;
        end
      end
      S_TRIM_DROP: begin
        if (vfound_r) cnt_inc[CNT_EVICTIONS] = 1'b1;
      end
      default: cnt_inc = '0;
    endcase
  end

  // Event counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 8; c++) cnt_r[c] <= '0;
    end else begin
      for (int c = 0; c < 8; c++) begin
        if (cnt_inc[c]) cnt_r[c] <= cnt_r[c] + 64'd1;
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= 5'd16;
      bounded_r     <= 1'b0;
      sealed_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ENTRIES:    max_entries_r <= cfg_data;
        CFG_BOUNDED_MODE:   bounded_r     <= cfg_data[0];
        CFG_ARCHIVE_SEALED: sealed_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer and table updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      next_gen_r <= 32'd1;
      live_r     <= '0;
      for (int e = 0; e < ENTRIES; e++) valid_r[e] <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r        <= in_req_type;
            key_r        <= KEY_BITS'(in_key_tag);
            tier_r       <= in_tier;
            reuse_r      <= in_reuse_only;
            ident_r      <= in_content_identity;
            gen_r        <= in_gen_in;
            sidx_r       <= in_stat_index;
            idx_r        <= '0;
            mfound_r     <= 1'b0;
            ffound_r     <= 1'b0;
            ev_r         <= '0;
            hit_r        <= 1'b0;
            gen_out_r    <= '0;
            start_load_r <= 1'b0;
            status_r     <= 1'b0;
            stat_r       <= '0;
            case (in_req_type)
              REQ_PREFETCH, REQ_LOAD, REQ_RELEASE: state_r <= S_LOOK;
              REQ_LOAD_DONE: state_r <= S_DONE_SCAN;
              REQ_READ_STAT: state_r <= S_STAT;
              REQ_CLEAR: begin
                for (int e = 0; e < ENTRIES; e++) valid_r[e] <= 1'b0;
                live_r  <= '0;
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end

        // One entry per cycle: first key match and first free slot.
        S_LOOK: begin
          if (cur_match && !mfound_r) begin
            mfound_r <= 1'b1;
            midx_r   <= idx_r;
          end
          if (!valid_r[idx_r] && !ffound_r) begin
            ffound_r <= 1'b1;
            fidx_r   <= idx_r;
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            state_r <= (req_r == REQ_RELEASE) ? S_REL : S_CHECK;
          end
        end

        // A hit with a different known identity is stale and goes away.
        S_CHECK: begin
          if (mfound_r && ident_r != 64'd0 && eident_r[midx_r] != ident_r) begin
            valid_r[midx_r] <= 1'b0;
            live_r          <= live_r - 1'b1;
            ev_r            <= ev_r + 5'd1;
            mfound_r        <= 1'b0;
            if (!ffound_r || midx_r < fidx_r) begin
              ffound_r <= 1'b1;
              fidx_r   <= midx_r;
            end
          end
          state_r <= S_DECIDE;
        end

        // A reuse-only fast miss retries on the cold tier.
        S_DECIDE: begin
          if (reuse_r && tier_fast && !mfound_r) begin
            tier_r   <= TIER_COLD;
            idx_r    <= '0;
            ffound_r <= 1'b0;
            state_r  <= S_LOOK;
          end else begin
            state_r <= S_APPLY;
          end
        end

        // Hit bookkeeping or insertion of a new entry.
        S_APPLY: begin
          if (mfound_r) begin
            hit_r     <= 1'b1;
            gen_out_r <= egen_r[midx_r];
            if (req_r == REQ_LOAD && epins_r[midx_r] != 8'hFF) begin
              epins_r[midx_r] <= epins_r[midx_r] + 8'd1;
            end
          end else if (!ffound_r) begin
            status_r <= 1'b1;
          end else begin
            valid_r[fidx_r]  <= 1'b1;
            ekey_r[fidx_r]   <= key_r;
            etier_r[fidx_r]  <= tier_r;
            eback_r[fidx_r]  <= sealed_r;
            eident_r[fidx_r] <= ident_r;
            epins_r[fidx_r]  <= (req_r == REQ_LOAD) ? 8'd1 : 8'd0;
            eready_r[fidx_r] <= 1'b0;
            egen_r[fidx_r]   <= next_gen_r;
            gen_out_r        <= next_gen_r;
            next_gen_r       <= next_gen_r + 32'd1;
            live_r           <= live_r + 1'b1;
            start_load_r     <= 1'b1;
          end
          state_r <= S_TRIM_CHK;
        end

        // Release drops one pin when the generation agrees.
        S_REL: begin
          if (mfound_r && egen_r[midx_r] == gen_r && epins_r[midx_r] != 8'd0) begin
            epins_r[midx_r] <= epins_r[midx_r] - 8'd1;
          end
          state_r <= S_TRIM_CHK;
        end

        S_TRIM_CHK: begin
          idx_r    <= '0;
          vfound_r <= 1'b0;
          if (bounded_r && CMP_W'(live_r) > limit) state_r <= S_TRIM_SCAN;
          else state_r <= S_OUT;
        end

        // Oldest eligible entry by insertion age.
        S_TRIM_SCAN: begin
          if (cur_elig && (!vfound_r || cur_age > best_age_r)) begin
            vfound_r   <= 1'b1;
            vidx_r     <= idx_r;
            best_age_r <= cur_age;
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_IDX) state_r <= S_TRIM_DROP;
        end

        S_TRIM_DROP: begin
          if (vfound_r) begin
            valid_r[vidx_r] <= 1'b0;
            live_r          <= live_r - 1'b1;
            ev_r            <= ev_r + 5'd1;
            state_r         <= S_TRIM_CHK;
          end else begin
            state_r <= S_OUT;
          end
        end

        S_DONE_SCAN: begin
          if (valid_r[idx_r] && egen_r[idx_r] == gen_r) eready_r[idx_r] <= 1'b1;
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_IDX) state_r <= S_OUT;
        end

        S_STAT: begin
          stat_r  <= (sidx_r == 3'(CNT_RETAINED)) ? 64'(live_r) : cnt_r[sidx_r];
          state_r <= S_OUT;
        end

        S_OUT: state_r <= S_IDLE;

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result beat.
  assign busy               = (state_r != S_IDLE);
  assign out_valid          = (state_r == S_OUT);
  assign out_hit            = hit_r;
  assign out_effective_tier = (req_r == REQ_PREFETCH || req_r == REQ_LOAD) ? tier_r : 2'd0;
  assign out_gen_out        = gen_out_r;
  assign out_start_load     = start_load_r;
  assign out_evicted_now    = ev_r;
  assign out_stat_value     = stat_r;
  assign out_status         = status_r;

  // Checks.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");

  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("block not idle after result beat");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LW'(ENTRIES)) else $error("live count beyond table size");

  a_full_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (!out_start_load && !out_hit))
    else $error("table full result with load or hit");

endmodule
